// ===== sv/est_pkg.sv =====
// Shared types, sizes and codes of the edit span tracking table.
`default_nettype none

package est_pkg;

    localparam int MAX_SPANS  = 16;
    localparam int POS_WIDTH  = 24;
    localparam int TAG_WIDTH  = 16;
    localparam int ACT_WIDTH  = 3;
    localparam int STAT_WIDTH = 2;
    localparam int SLOT_AW    = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;

    typedef logic [POS_WIDTH-1:0]  t_pos;
    typedef logic [TAG_WIDTH-1:0]  t_tag;
    typedef logic [STAT_WIDTH-1:0] t_stat;
    typedef logic [ACT_WIDTH-1:0]  t_act;

    localparam t_act ACT_SET    = 3'd0;
    localparam t_act ACT_REMOVE = 3'd1;
    localparam t_act ACT_FIND   = 3'd2;
    localparam t_act ACT_INSERT = 3'd3;
    localparam t_act ACT_DELETE = 3'd4;

    localparam t_stat ST_UNCHANGED = 2'd0;
    localparam t_stat ST_EDITED    = 2'd1;
    localparam t_stat ST_CLOBBERED = 2'd2;

    typedef struct packed {
        t_act action;
        t_tag span_id;
        t_pos pos;
        t_pos span_end;
        t_pos length;
    } t_in_word;

    typedef struct packed {
        logic  found;
        t_pos  begin_out;
        t_pos  end_out;
        t_stat state_code;
        logic  table_full;
    } t_out_word;

    typedef struct packed {
        t_tag  tag;
        t_pos  begin_pos;
        t_pos  end_pos;
        t_stat status;
    } t_slot;

    typedef struct packed {
        logic is_delete;
        t_pos pos;
        t_pos len;
    } t_edit_cmd;

endpackage

`default_nettype wire

// ===== sv/est_slot_store.sv =====
// Slot memory: one write port and one registered read port.
`default_nettype none

module est_slot_store import est_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_re,
    input  wire logic [SLOT_AW-1:0] i_raddr,
    output t_slot                   o_rdata,
    input  wire logic               i_we,
    input  wire logic [SLOT_AW-1:0] i_waddr,
    input  wire t_slot              i_wdata
);

    t_slot r_mem [MAX_SPANS];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/est_edit_unit.sv =====
// Per-slot update of a stored range for an insertion or a deletion.
`default_nettype none

module est_edit_unit import est_pkg::*; (
    input  wire t_edit_cmd i_cmd,
    input  wire t_slot     i_slot,
    output t_slot          o_slot
);

    logic [POS_WIDTH:0] w_b;
    logic [POS_WIDTH:0] w_e;
    logic [POS_WIDTH:0] w_p;
    logic [POS_WIDTH:0] w_d;
    logic [POS_WIDTH:0] w_b_add;
    logic [POS_WIDTH:0] w_e_add;
    t_pos               w_b_sat;
    t_pos               w_e_sat;
    logic               w_bin;
    logic               w_ein;

    assign w_b     = {1'b0, i_slot.begin_pos};
    assign w_e     = {1'b0, i_slot.end_pos};
    assign w_p     = {1'b0, i_cmd.pos};
    assign w_d     = w_p + {1'b0, i_cmd.len};
    assign w_b_add = w_b + {1'b0, i_cmd.len};
    assign w_e_add = w_e + {1'b0, i_cmd.len};
    // Sums past the top of the position range stick at all ones.
    assign w_b_sat = w_b_add[POS_WIDTH] ? '1 : w_b_add[POS_WIDTH-1:0];
    assign w_e_sat = w_e_add[POS_WIDTH] ? '1 : w_e_add[POS_WIDTH-1:0];
    assign w_bin   = (w_p <= w_b) && (w_b <= w_d);
    assign w_ein   = (w_p <= w_e) && (w_e <= w_d);

    always_comb begin
        o_slot = i_slot;
        if (!i_cmd.is_delete) begin
            if (w_e <= w_p) begin
                o_slot = i_slot;
            end else if (w_p <= w_b) begin
                o_slot.begin_pos = w_b_sat;
                o_slot.end_pos   = w_e_sat;
            end else begin
                o_slot.end_pos = w_e_sat;
                if (i_slot.status == ST_UNCHANGED) begin
                    o_slot.status = ST_EDITED;
                end
            end
        end else begin
            if (w_d <= w_b) begin
                o_slot.begin_pos = i_slot.begin_pos - i_cmd.len;
                o_slot.end_pos   = i_slot.end_pos - i_cmd.len;
            end else if (w_e <= w_p) begin
                o_slot = i_slot;
            end else if ((w_b <= w_p) && (w_p <= w_e) && (w_b <= w_d) && (w_d <= w_e)) begin
                o_slot.end_pos = i_slot.end_pos - i_cmd.len;
                if (i_slot.status == ST_UNCHANGED) begin
                    o_slot.status = ST_EDITED;
                end
            end else if (w_bin && w_ein) begin
                o_slot.begin_pos = i_cmd.pos;
                o_slot.end_pos   = i_cmd.pos;
                o_slot.status    = ST_CLOBBERED;
            end else if (w_bin) begin
                o_slot.begin_pos = i_cmd.pos;
                o_slot.end_pos   = i_slot.end_pos - i_cmd.len;
                o_slot.status    = ST_CLOBBERED;
            end else if (w_ein) begin
                o_slot.end_pos = i_cmd.pos;
                o_slot.status  = ST_CLOBBERED;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/edit_span_tracking_table.sv =====
// Top level of the edit span tracking table: sequencer, valid bits and result register.
`default_nettype none

// The table holds up to MAX_SPANS tagged ranges (begin, end, status) of an edited
// text buffer. Every accepted word sweeps the slot memory once, reading one slot per
// cycle through its single registered read port and writing updated ranges back in
// the following cycle. A set adds a write step after the sweep. The next word is
// accepted only once the result of the previous one has entered the output register,
// so words are never overlapped. Exactly one result word comes out per input word.
// Find reports the lowest slot whose tag matches; set overwrites that slot in place
// or else takes the lowest free one, and flags table_full when there is neither.
// Insert and delete adjust every stored range, an insert saturating positions at all
// ones. The valid bits live in flip-flops cleared by reset; the slot memory itself is
// never cleared and needs no start-up pass, since only valid slots are ever used. A
// finished result is held in an output register, so the next word may be accepted
// while it waits.

module edit_span_tracking_table import est_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_word i_in_word,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_word     o_out_word
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SWEEP  = 2'd1;
    localparam logic [1:0] ST_WRITE  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam logic [SLOT_AW:0]   SWEEP_LEN = (SLOT_AW+1)'(MAX_SPANS);
    localparam logic [SLOT_AW-1:0] LAST_IDX  = SLOT_AW'(MAX_SPANS - 1);

    logic [1:0]           r_state;
    logic [1:0]           n_state;
    t_in_word             r_cmd;
    logic [SLOT_AW:0]     r_rd_cnt;
    logic                 r_chk_vld;
    logic [SLOT_AW-1:0]   r_chk_idx;
    logic [MAX_SPANS-1:0] r_valid;
    logic                 r_hit;
    logic [SLOT_AW-1:0]   r_hit_idx;
    t_slot                r_hit_data;
    logic                 r_free_fnd;
    logic [SLOT_AW-1:0]   r_free_idx;
    logic                 r_out_valid;
    t_out_word            r_out_word;
    t_out_word            n_out_word;

    logic               w_accept;
    logic               w_mem_re;
    logic [SLOT_AW-1:0] w_mem_raddr;
    t_slot              w_mem_rdata;
    logic               w_mem_we;
    logic [SLOT_AW-1:0] w_mem_waddr;
    t_slot              w_mem_wdata;
    logic               w_chk_live;
    logic               w_chk_match;
    logic               w_chk_last;
    logic               w_is_edit;
    logic               w_out_free;
    t_edit_cmd          w_edit_cmd;
    t_slot              w_edit_slot;
    t_slot              w_set_slot;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // Read issue: one slot per cycle until every slot has been requested.
    assign w_mem_re    = (r_state == ST_SWEEP) && (r_rd_cnt < SWEEP_LEN);
    assign w_mem_raddr = r_rd_cnt[SLOT_AW-1:0];

    // Check stage: the slot read in the previous cycle is on the memory output.
    assign w_chk_live  = r_chk_vld && r_valid[r_chk_idx];
    assign w_chk_match = w_chk_live && (w_mem_rdata.tag == r_cmd.span_id);
    assign w_chk_last  = r_chk_vld && (r_chk_idx == LAST_IDX);
    assign w_is_edit   = r_cmd.action inside {ACT_INSERT, ACT_DELETE};

    assign w_edit_cmd.is_delete = (r_cmd.action == ACT_DELETE);
    assign w_edit_cmd.pos       = r_cmd.pos;
    assign w_edit_cmd.len       = r_cmd.length;

    // A set stores the range with the end raised to the begin where it lies below.
    assign w_set_slot.tag       = r_cmd.span_id;
    assign w_set_slot.begin_pos = r_cmd.pos;
    assign w_set_slot.end_pos   = (r_cmd.span_end < r_cmd.pos) ? r_cmd.pos : r_cmd.span_end;
    assign w_set_slot.status    = ST_UNCHANGED;

    // The write-back of slot i lands while slot i+1 is being read, so the two
    // never touch the same entry and no forwarding is needed.
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = r_chk_idx;
        w_mem_wdata = w_edit_slot;
        if (r_state == ST_WRITE) begin
            w_mem_we    = r_hit || r_free_fnd;
            w_mem_waddr = r_hit ? r_hit_idx : r_free_idx;
            w_mem_wdata = w_set_slot;
        end else if ((r_state == ST_SWEEP) && w_chk_live && w_is_edit) begin
            w_mem_we = 1'b1;
        end
    end

    est_slot_store u_store (
        .i_clk   (i_clk),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata)
    );

    est_edit_unit u_edit (
        .i_cmd  (w_edit_cmd),
        .i_slot (w_mem_rdata),
        .o_slot (w_edit_slot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (w_chk_last) begin
                    n_state = (r_cmd.action == ACT_SET) ? ST_WRITE : ST_FINISH;
                end
            end
            ST_WRITE: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Result word of the finishing step: all zero but for a find hit or a refused set.
    always_comb begin
        n_out_word            = '0;
        n_out_word.table_full = (r_cmd.action == ACT_SET) && !r_hit && !r_free_fnd;
        if ((r_cmd.action == ACT_FIND) && r_hit) begin
            n_out_word.found      = 1'b1;
            n_out_word.begin_out  = r_hit_data.begin_pos;
            n_out_word.end_out    = r_hit_data.end_pos;
            n_out_word.state_code = r_hit_data.status;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rd_cnt    <= '0;
            r_chk_vld   <= 1'b0;
            r_valid     <= '0;
            r_hit       <= 1'b0;
            r_free_fnd  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_chk_vld <= w_mem_re;
            if (w_accept) begin
                r_rd_cnt   <= '0;
                r_hit      <= 1'b0;
                r_free_fnd <= 1'b0;
            end else if (w_mem_re) begin
                r_rd_cnt <= r_rd_cnt + 1'b1;
            end
            if (r_state == ST_SWEEP) begin
                if (w_chk_match && !r_hit) begin
                    r_hit <= 1'b1;
                end
                if (r_chk_vld && !w_chk_live && !r_free_fnd) begin
                    r_free_fnd <= 1'b1;
                end
            end
            if ((r_state == ST_WRITE) && (r_hit || r_free_fnd)) begin
                r_valid[w_mem_waddr] <= 1'b1;
            end
            if ((r_state == ST_FINISH) && w_out_free && r_hit &&
                (r_cmd.action == ACT_REMOVE)) begin
                r_valid[r_hit_idx] <= 1'b0;
            end
            if ((r_state == ST_FINISH) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_in_word;
        end
        if (w_mem_re) begin
            r_chk_idx <= w_mem_raddr;
        end
        if ((r_state == ST_SWEEP) && w_chk_match && !r_hit) begin
            r_hit_idx  <= r_chk_idx;
            r_hit_data <= w_mem_rdata;
        end
        if ((r_state == ST_SWEEP) && r_chk_vld && !w_chk_live && !r_free_fnd) begin
            r_free_idx <= r_chk_idx;
        end
        if ((r_state == ST_FINISH) && w_out_free) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // The write-back never targets the slot being read in the same cycle.
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mem_we && w_mem_re) |-> (w_mem_waddr != w_mem_raddr))
        else $error("slot memory read and write hit the same entry");

    // An accepted word always starts a sweep from the first slot.
    a_accept_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> ((r_state == ST_SWEEP) && (r_rd_cnt == '0)))
        else $error("accepted word did not start a sweep");

    // A set that hits a tag never writes through a slot index that is not valid.
    a_set_hits_live_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_WRITE) && r_hit) |-> r_valid[r_hit_idx])
        else $error("set overwrote a slot that is not valid");

    // A new result only appears out of the finishing step.
    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_FINISH))
        else $error("result word appeared outside the finishing step");

endmodule

`default_nettype wire
